FILE: hdl/bsfi_pkg.sv
// Shared types, constants and opcode tables for the byte stream fault injector.
`default_nettype none
package bsfi_pkg;

  localparam int POS_BITS_DEF  = 30;
  localparam int DRAW_BITS_DEF = 15;

  localparam int TGT_W      = 31;
  localparam int RANGE_W    = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;

  localparam logic [TGT_W-1:0] TGT_MAX = {TGT_W{1'b1}};

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_START_OFFSET = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END_OFFSET   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE_MIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE_MAX   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MODE_FLAGS   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ADD_AMOUNT   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_AMOUNT = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_REPLACE_PAIR = 3'd7;

  // mode flag bit positions
  localparam int MODE_RANDOM  = 0;
  localparam int MODE_REPLACE = 1;
  localparam int MODE_ADD     = 2;
  localparam int MODE_SHIFT   = 3;
  localparam int MODE_PROTECT = 4;

  typedef struct packed {
    logic [4:0]        mode_flags;
    logic signed [8:0] add_amount;
    logic signed [4:0] shift_amount;
    logic [15:0]       replace_pair;
  } bsfi_mode_t;

  typedef struct packed {
    logic [1:0] history_count;
    logic [7:0] prev_out_one;
    logic [7:0] prev_out_two;
  } bsfi_hist_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       was_protected;
  } bsfi_result_t;

  function automatic logic in_first_list(input logic [7:0] b);
    return (b == 8'h20) || (b == 8'h4C) || (b == 8'h6C);
  endfunction

  function automatic logic in_second_list(input logic [7:0] b);
    logic hit;
    unique case (b)
      8'h10, 8'h20, 8'h30, 8'h4C, 8'h50, 8'h6C,
      8'h70, 8'h90, 8'hB0, 8'hD0, 8'hF0: hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

  function automatic logic in_third_list(input logic [7:0] b);
    logic hit;
    unique case (b)
      8'h00, 8'h08, 8'h10, 8'h20, 8'h28, 8'h30, 8'h40, 8'h48, 8'h4C, 8'h50,
      8'h60, 8'h68, 8'h6C, 8'h70, 8'h78, 8'h90, 8'hB0, 8'hD0, 8'hF0: hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

  function automatic logic is_halt(input logic [7:0] b);
    logic hit;
    unique case (b)
      8'h00, 8'h02, 8'h08, 8'h12, 8'h22, 8'h28, 8'h32, 8'h42, 8'h48,
      8'h52, 8'h62, 8'h68, 8'h72, 8'h78, 8'h92, 8'hB2, 8'hD2, 8'hF2: hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

  // negative amounts shift right; magnitude of eight or more clears the byte
  function automatic logic [7:0] shift_by_amount(input logic [7:0] b, input logic [4:0] raw);
    logic [4:0] mag;
    logic [7:0] res;
    mag = 5'(5'd0 - raw);
    if (raw[4]) begin
      res = (mag >= 5'd8) ? 8'd0 : (b >> mag[2:0]);
    end else begin
      res = (raw >= 5'd8) ? 8'd0 : (b << raw[2:0]);
    end
    return res;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/bsfi_if.sv
// Request channel interfaces: input byte stream and corrupted output stream.
`default_nettype none
interface bsfi_in_if #(
  parameter int DRAW_BITS = bsfi_pkg::DRAW_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic [7:0]           data_byte;
  logic [DRAW_BITS-1:0] rand_draw;
  logic [7:0]           rand_byte;
  logic                 first_of_stream;

  modport source (output valid, data_byte, rand_draw, rand_byte, first_of_stream,
                  input ready);
  modport sink   (input valid, data_byte, rand_draw, rand_byte, first_of_stream,
                  output ready);
endinterface

interface bsfi_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       was_target;
  logic       was_protected;

  modport source (output valid, out_byte, was_target, was_protected, input ready);
  modport sink   (input valid, out_byte, was_target, was_protected, output ready);
endinterface
`default_nettype wire

FILE: hdl/bsfi_mod_unit.sv
// Serial restoring remainder unit: one dividend bit per cycle.
`default_nettype none
module bsfi_mod_unit #(
  parameter int DRAW_BITS = bsfi_pkg::DRAW_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [DRAW_BITS-1:0]         dividend,
  input  wire logic [bsfi_pkg::RANGE_W-1:0] divisor,
  output logic                              done,
  output logic [bsfi_pkg::RANGE_W-1:0]      rem
);
  import bsfi_pkg::*;

  localparam int CNT_W = $clog2(DRAW_BITS + 1);

  logic                 busy;
  logic [CNT_W-1:0]     count;
  logic [DRAW_BITS-1:0] dvd;
  logic [RANGE_W-1:0]   dsr;
  logic [RANGE_W-1:0]   trial;
  logic                 fits;

  // remainder stays below divisor, which is below 2^31
  assign trial = {rem[RANGE_W-2:0], dvd[DRAW_BITS-1]};
  assign fits  = (trial >= dsr);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CNT_W'(DRAW_BITS);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[DRAW_BITS-2:0], 1'b0};
      rem <= fits ? (trial - dsr) : trial;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/bsfi_corrupt.sv
// Byte corruption: protection check, random/replace/add/shift and halt fix-up.
`default_nettype none
module bsfi_corrupt (
  input  wire logic                   is_target,
  input  wire logic [7:0]             data_byte,
  input  wire logic [7:0]             rand_byte,
  input  wire bsfi_pkg::bsfi_mode_t   mode,
  input  wire bsfi_pkg::bsfi_hist_t   hist,
  output bsfi_pkg::bsfi_result_t      res
);
  import bsfi_pkg::*;

  logic       guard;
  logic       prot;
  logic       swap;
  logic [7:0] added;
  logic [7:0] shifted;
  logic [7:0] changed;

  assign guard = mode.mode_flags[MODE_PROTECT];

  // jump/branch pattern over the current byte and up to two earlier outputs
  assign prot = guard && in_third_list(data_byte)
             && ((hist.history_count == 2'd0) || in_second_list(hist.prev_out_one))
             && ((hist.history_count <= 2'd1) || in_first_list(hist.prev_out_two));

  assign swap    = mode.mode_flags[MODE_REPLACE] && (data_byte == mode.replace_pair[15:8]);
  assign added   = mode.mode_flags[MODE_ADD] ? (data_byte + mode.add_amount[7:0]) : data_byte;
  assign shifted = mode.mode_flags[MODE_SHIFT] ? shift_by_amount(added, mode.shift_amount)
                                               : added;

  always_comb begin
    priority if (mode.mode_flags[MODE_RANDOM]) begin
      changed = rand_byte;
    end else if (swap) begin
      changed = mode.replace_pair[7:0];
    end else begin
      changed = shifted;
    end
    if (guard && is_halt(changed)) begin
      changed = changed + 8'd1;
    end
  end

  always_comb begin
    res.out_byte      = data_byte;
    res.was_protected = 1'b0;
    if (is_target) begin
      if (prot) begin
        res.was_protected = 1'b1;
      end else begin
        res.out_byte = changed;
      end
    end
  end

endmodule
`default_nettype wire

FILE: hdl/byte_stream_fault_injector_unit.sv
// Top level of the byte stream fault injector.
// Takes one byte request at a time and returns one result per byte. A byte that
// is not a corruption target leaves the block free for the next byte; a target
// byte also computes its next target offset, which holds the block off until
// the stride remainder rand_draw mod (stride_max - lo + 1), lo being stride_min
// or one if it is zero, is formed in a serial restoring unit, one draw bit per
// cycle. The result sits in a single output register; while it waits there the
// next byte is held off until the result is taken. Configuration writes take
// effect at once and are meant for idle periods. No clearing pass after reset.
`default_nettype none
module byte_stream_fault_injector_unit #(
  parameter int POS_BITS  = bsfi_pkg::POS_BITS_DEF,
  parameter int DRAW_BITS = bsfi_pkg::DRAW_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [bsfi_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bsfi_pkg::CFG_DATA_W-1:0] cfg_data,
  bsfi_in_if.sink                              din,
  bsfi_out_if.source                           dout
);
  import bsfi_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DIV  = 1'b1;

  // configuration
  logic [TGT_W-1:0] start_offset;
  logic [TGT_W-1:0] end_offset;
  logic [TGT_W-1:0] stride_min;
  logic [TGT_W-1:0] stride_max;
  bsfi_mode_t       mode;

  // stream state
  logic                state;
  logic [POS_BITS-1:0] position;
  logic [TGT_W-1:0]    next_target;
  bsfi_hist_t          hist;
  logic                restart_pending;
  logic [RANGE_W-1:0]  base;

  // output register
  logic         out_valid;
  bsfi_result_t out_res;
  logic         out_tgt;

  logic                accept;
  logic                restart;
  logic [POS_BITS-1:0] pos_eff;
  logic [TGT_W-1:0]    tgt_eff;
  bsfi_hist_t          hist_eff;
  logic [RANGE_W-1:0]  pos_ext;
  logic                is_target;
  bsfi_result_t        res;
  logic [TGT_W-1:0]    lo;
  logic                degenerate;
  logic [RANGE_W-1:0]  divisor;
  logic [DRAW_BITS-1:0] dividend;
  logic                div_done;
  logic [RANGE_W-1:0]  rem;
  logic [RANGE_W:0]    sum;
  logic [TGT_W-1:0]    target_next;

  assign din.ready = (state == ST_IDLE) && (!out_valid || dout.ready);
  assign accept    = din.valid && din.ready;

  assign restart  = din.first_of_stream || restart_pending;
  assign pos_eff  = restart ? '0 : position;
  assign tgt_eff  = restart ? start_offset : next_target;
  assign hist_eff = restart ? '0 : hist;
  assign pos_ext  = RANGE_W'(pos_eff);

  assign is_target = (pos_ext == {1'b0, tgt_eff}) && (pos_ext < {1'b0, end_offset});

  bsfi_corrupt u_corrupt (
    .is_target (is_target),
    .data_byte (din.data_byte),
    .rand_byte (din.rand_byte),
    .mode      (mode),
    .hist      (hist_eff),
    .res       (res)
  );

  // stride_max below the effective minimum gives a fixed stride of the minimum
  assign lo         = (stride_min == '0) ? TGT_W'(1) : stride_min;
  assign degenerate = (stride_max < lo);
  assign divisor    = degenerate ? RANGE_W'(1)
                                 : ({1'b0, stride_max} - {1'b0, lo} + RANGE_W'(1));
  assign dividend   = degenerate ? '0 : din.rand_draw;

  bsfi_mod_unit #(
    .DRAW_BITS (DRAW_BITS)
  ) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (accept && is_target),
    .dividend (dividend),
    .divisor  (divisor),
    .done     (div_done),
    .rem      (rem)
  );

  assign sum         = {1'b0, base} + {1'b0, rem};
  assign target_next = (sum > (RANGE_W + 1)'(TGT_MAX)) ? TGT_MAX : sum[TGT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      start_offset      <= '0;
      end_offset        <= '0;
      stride_min        <= TGT_W'(1);
      stride_max        <= TGT_W'(1);
      mode.mode_flags   <= '0;
      mode.add_amount   <= '0;
      mode.shift_amount <= '0;
      mode.replace_pair <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_START_OFFSET: start_offset      <= cfg_data[TGT_W-1:0];
        REG_END_OFFSET:   end_offset        <= cfg_data[TGT_W-1:0];
        REG_STRIDE_MIN:   stride_min        <= cfg_data[TGT_W-1:0];
        REG_STRIDE_MAX:   stride_max        <= cfg_data[TGT_W-1:0];
        REG_MODE_FLAGS:   mode.mode_flags   <= cfg_data[4:0];
        REG_ADD_AMOUNT:   mode.add_amount   <= cfg_data[8:0];
        REG_SHIFT_AMOUNT: mode.shift_amount <= cfg_data[4:0];
        REG_REPLACE_PAIR: mode.replace_pair <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      restart_pending <= 1'b1;
      position        <= '0;
      next_target     <= '0;
      hist            <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (accept) begin
        restart_pending        <= 1'b0;
        position               <= pos_eff + 1'b1;
        next_target            <= tgt_eff;
        hist.prev_out_one      <= res.out_byte;
        hist.prev_out_two      <= hist_eff.prev_out_one;
        hist.history_count     <= (hist_eff.history_count < 2'd2)
                                  ? hist_eff.history_count + 2'd1 : 2'd2;
        out_valid              <= 1'b1;
        if (is_target) begin
          state <= ST_DIV;
        end
      end else if (dout.ready) begin
        out_valid <= 1'b0;
      end
      if (state == ST_DIV && div_done) begin
        next_target <= target_next;
        state       <= ST_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_res <= res;
      out_tgt <= is_target;
      base    <= {1'b0, tgt_eff} + {1'b0, lo};
    end
  end

  assign dout.valid         = out_valid;
  assign dout.out_byte      = out_res.out_byte;
  assign dout.was_target    = out_tgt;
  assign dout.was_protected = out_res.was_protected;

endmodule
`default_nettype wire

FILE: hdl/bsfi_checker.sv
// Port-level checks for the byte stream fault injector, bound to the top level.
`default_nettype none
module bsfi_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_byte,
  input wire logic       was_target,
  input wire logic       was_protected
);

  // a protected byte is always a target
  a_prot_is_target: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!was_protected || was_target))
    else $error("protected result without target");

  // every accepted byte shows a result on the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> out_valid)
    else $error("accepted byte produced no result");

  // a stalled result must not be overwritten by a new byte
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("input taken while result stalled");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_byte) && $stable(was_target) && $stable(was_protected)))
    else $error("stalled result changed");

endmodule

bind byte_stream_fault_injector_unit bsfi_checker u_bsfi_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (din.valid),
  .in_ready      (din.ready),
  .out_valid     (dout.valid),
  .out_ready     (dout.ready),
  .out_byte      (dout.out_byte),
  .was_target    (dout.was_target),
  .was_protected (dout.was_protected)
);
`default_nettype wire

FILE: tb/byte_stream_fault_injector_unit_tb.sv
// Self-checking testbench: byte requests in, corrupted bytes out, checked against a local model.
module byte_stream_fault_injector_unit_tb;
  import bsfi_pkg::*;

  localparam int DW          = DRAW_BITS_DEF;
  localparam int QUIET_LIMIT = 2000;
  localparam int SETTLE      = 24;
  localparam logic [30:0] TOP = 31'h4000_0000;

  localparam logic [4:0] F_RANDOM  = 5'(1 << MODE_RANDOM);
  localparam logic [4:0] F_REPLACE = 5'(1 << MODE_REPLACE);
  localparam logic [4:0] F_ADD     = 5'(1 << MODE_ADD);
  localparam logic [4:0] F_SHIFT   = 5'(1 << MODE_SHIFT);
  localparam logic [4:0] F_PROTECT = 5'(1 << MODE_PROTECT);

  typedef struct packed {
    logic [7:0] out_byte;
    logic       was_target;
    logic       was_protected;
  } fault_out_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  bsfi_in_if #(.DRAW_BITS(DW)) din_if ();
  bsfi_out_if dout_if ();

  byte_stream_fault_injector_unit #(.POS_BITS(POS_BITS_DEF), .DRAW_BITS(DW)) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .din       (din_if),
    .dout      (dout_if)
  );

  // model copy of registers and stream state
  logic [30:0]             m_start, m_end, m_smin, m_smax, m_tgt;
  logic [4:0]              m_mode, m_shift;
  logic [8:0]              m_add;
  logic [15:0]             m_pair;
  logic [POS_BITS_DEF-1:0] m_pos;
  logic [7:0]              m_prev1, m_prev2;
  logic [1:0]              m_hist;
  logic                    m_restart;

  fault_out_t awaited[$];
  int errs, quiet, gap_pct, stall_pct, recv_hold;

  always begin
    clk = 1'b0; #4;
    clk = 1'b1; #4;
  end

  function automatic fault_out_t inject(input logic [7:0] data, input logic [DW-1:0] draw,
                                        input logic [7:0] rbyte, input logic first);
    fault_out_t r;
    logic [7:0] b;
    logic [63:0] lo, hi, nt;
    int n;
    b = data;
    r.was_target = 1'b0;
    r.was_protected = 1'b0;
    if (first || m_restart) begin
      m_pos = '0;
      m_tgt = m_start;
      m_hist = '0;
      m_prev1 = '0;
      m_prev2 = '0;
      m_restart = 1'b0;
    end
    if (31'(m_pos) == m_tgt && 31'(m_pos) < m_end) begin
      r.was_target = 1'b1;
      // skip bytes that complete a jump or branch sequence
      if (m_mode[MODE_PROTECT]
          && data inside {8'h00, 8'h08, 8'h10, 8'h20, 8'h28, 8'h30, 8'h40, 8'h48, 8'h4C,
                          8'h50, 8'h60, 8'h68, 8'h6C, 8'h70, 8'h78, 8'h90, 8'hB0, 8'hD0,
                          8'hF0}
          && (m_hist < 2'd1 || m_prev1 inside {8'h10, 8'h20, 8'h30, 8'h4C, 8'h50, 8'h6C,
                                                8'h70, 8'h90, 8'hB0, 8'hD0, 8'hF0})
          && (m_hist < 2'd2 || m_prev2 inside {8'h20, 8'h4C, 8'h6C})) begin
        r.was_protected = 1'b1;
      end else begin
        if (m_mode[MODE_RANDOM]) begin
          b = rbyte;
        end else if (m_mode[MODE_REPLACE] && data == m_pair[15:8]) begin
          b = m_pair[7:0];
        end else begin
          if (m_mode[MODE_ADD]) b = b + m_add[7:0];
          if (m_mode[MODE_SHIFT]) begin
            if (m_shift[4]) begin
              n = 32 - int'(m_shift);
              b = (n >= 8) ? 8'd0 : b >> n;
            end else begin
              b = (m_shift >= 5'd8) ? 8'd0 : b << m_shift;
            end
          end
        end
        if (m_mode[MODE_PROTECT]
            && b inside {8'h00, 8'h02, 8'h08, 8'h12, 8'h22, 8'h28, 8'h32, 8'h42, 8'h48,
                         8'h52, 8'h62, 8'h68, 8'h72, 8'h78, 8'h92, 8'hB2, 8'hD2, 8'hF2})
          b = b + 8'd1;
      end
      lo = (m_smin == '0) ? 64'd1 : 64'(m_smin);
      hi = 64'(m_smax);
      if (hi < lo) nt = 64'(m_tgt) + lo;
      else nt = 64'(m_tgt) + lo + 64'(draw) % (hi - lo + 64'd1);
      m_tgt = (nt > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : nt[30:0];
    end
    m_prev2 = m_prev1;
    m_prev1 = b;
    if (m_hist < 2'd2) m_hist = m_hist + 2'd1;
    m_pos = m_pos + 1'b1;
    r.out_byte = b;
    return r;
  endfunction

  // register copy, prediction, result check and watchdog
  always @(posedge clk) begin
    fault_out_t got, want;
    if (rst) begin
      m_start = '0; m_end = '0; m_smin = 31'd1; m_smax = 31'd1;
      m_mode = '0; m_add = '0; m_shift = '0; m_pair = '0;
      m_pos = '0; m_tgt = '0; m_prev1 = '0; m_prev2 = '0; m_hist = '0;
      m_restart = 1'b1;
      quiet = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_START_OFFSET: m_start = cfg_data[30:0];
          REG_END_OFFSET:   m_end = cfg_data[30:0];
          REG_STRIDE_MIN:   m_smin = cfg_data[30:0];
          REG_STRIDE_MAX:   m_smax = cfg_data[30:0];
          REG_MODE_FLAGS:   m_mode = cfg_data[4:0];
          REG_ADD_AMOUNT:   m_add = cfg_data[8:0];
          REG_SHIFT_AMOUNT: m_shift = cfg_data[4:0];
          REG_REPLACE_PAIR: m_pair = cfg_data[15:0];
          default: ;
        endcase
      end
      if (din_if.valid && din_if.ready)
        awaited.push_back(inject(din_if.data_byte, din_if.rand_draw, din_if.rand_byte,
                                 din_if.first_of_stream));
      if (dout_if.valid && dout_if.ready) begin
        got = {dout_if.out_byte, dout_if.was_target, dout_if.was_protected};
        if (awaited.size() == 0) begin
          errs++;
          $display("%0t: unexpected output: expected none, got byte %h target %b prot %b",
                   $time, got.out_byte, got.was_target, got.was_protected);
        end else begin
          want = awaited.pop_front();
          if (got !== want) begin
            errs++;
            $display("%0t: mismatch: expected byte %h target %b prot %b, got byte %h target %b prot %b",
                     $time, want.out_byte, want.was_target, want.was_protected,
                     got.out_byte, got.was_target, got.was_protected);
          end
        end
      end
      if ((din_if.valid && din_if.ready) || (dout_if.valid && dout_if.ready)) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // result side: random stalls, or a counted hold-off on request
  always @(posedge clk) begin
    if (recv_hold > 0) begin
      recv_hold = recv_hold - 1;
      dout_if.ready <= 1'b0;
    end else begin
      dout_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic wait_drained();
    din_if.valid <= 1'b0;
    @(posedge clk);
    while (awaited.size() != 0) @(posedge clk);
  endtask

  task automatic send_byte(input logic [7:0] data, input logic [DW-1:0] draw,
                           input logic [7:0] rbyte, input logic first);
    int idle;
    idle = 0;
    while (gap_pct != 0 && $urandom_range(99) < gap_pct) idle++;
    if (idle > 0) begin
      din_if.valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    din_if.valid <= 1'b1;
    din_if.data_byte <= data;
    din_if.rand_draw <= draw;
    din_if.rand_byte <= rbyte;
    din_if.first_of_stream <= first;
    do @(posedge clk); while (!din_if.ready);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  // stride unit may still be busy after the last result, so let it finish
  task automatic configure(input logic [30:0] start_off, end_off, smin, smax,
                           input logic [4:0] mode, input logic [8:0] add,
                           input logic [4:0] shift, input logic [15:0] pair);
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    write_reg(REG_START_OFFSET, start_off);
    write_reg(REG_END_OFFSET, end_off);
    write_reg(REG_STRIDE_MIN, smin);
    write_reg(REG_STRIDE_MAX, smax);
    write_reg(REG_MODE_FLAGS, 31'(mode));
    write_reg(REG_ADD_AMOUNT, 31'(add));
    write_reg(REG_SHIFT_AMOUNT, 31'(shift));
    write_reg(REG_REPLACE_PAIR, 31'(pair));
    cfg_we <= 1'b0;
  endtask

  // mix of opcode-like bytes, replace matches and plain noise
  task automatic random_bytes(input int count);
    logic [7:0] data;
    int pick;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        case ($urandom_range(9))
          0: data = 8'h20;
          1: data = 8'h4C;
          2: data = 8'h6C;
          3: data = 8'h10;
          4: data = 8'hD0;
          5: data = 8'h90;
          6: data = 8'h08;
          7: data = 8'h00;
          8: data = 8'h78;
          default: data = 8'hF2;
        endcase
      end else if (pick < 50) begin
        data = m_pair[15:8];
      end else begin
        data = 8'($urandom_range(255));
      end
      send_byte(data, DW'($urandom_range((1 << DW) - 1)), 8'($urandom_range(255)),
                $urandom_range(99) < 3);
    end
  endtask

  task automatic test_reset_defaults();
    send_byte(8'h00, '0, 8'hFF, 1'b0);
    send_byte(8'hFF, '1, 8'h00, 1'b0);
    send_byte(8'h5A, DW'(15'h5555), 8'hA5, 1'b1);
  endtask

  task automatic test_corrupt_modes();
    configure(31'd0, TOP, 31'd1, 31'd1, F_REPLACE | F_ADD, 9'h101, 5'd0, 16'h5AA5);
    send_byte(8'h5A, '0, 8'h00, 1'b1);
    send_byte(8'h00, '1, 8'h00, 1'b0);
    send_byte(8'hFF, '0, 8'h00, 1'b0);
    // random byte wins over all other modes
    configure(31'd0, TOP, 31'd1, 31'd1, F_RANDOM | F_REPLACE | F_ADD | F_SHIFT, 9'h0FF,
              5'h18, 16'hFF00);
    send_byte(8'hFF, '0, 8'h00, 1'b0);
    send_byte(8'h00, '1, 8'hFF, 1'b0);
    configure(31'd0, TOP, 31'd1, 31'd1, F_ADD | F_SHIFT, 9'h1FF, 5'h08, 16'h0000);
    send_byte(8'h81, '0, 8'h00, 1'b0);
    configure(31'd0, TOP, 31'd1, 31'd1, F_SHIFT, 9'h000, 5'h18, 16'h0000);
    send_byte(8'hFF, '1, 8'h00, 1'b0);
    configure(31'd0, TOP, 31'd1, 31'd1, F_SHIFT, 9'h000, 5'h1F, 16'h0000);
    send_byte(8'hFF, '0, 8'h00, 1'b0);
    configure(31'd0, TOP, 31'd1, 31'd1, F_REPLACE | F_SHIFT, 9'h000, 5'h03, 16'h1234);
    send_byte(8'hFF, '1, 8'h00, 1'b0);
  endtask

  // zero stride_min acts as one, so every byte is a target here
  task automatic test_opcode_guard();
    configure(31'd0, TOP, 31'd0, 31'd0, F_PROTECT | F_ADD, 9'h000, 5'd0, 16'h0000);
    send_byte(8'h20, '0, 8'h00, 1'b1);
    send_byte(8'hD0, '1, 8'h00, 1'b0);
    send_byte(8'h10, '0, 8'h00, 1'b0);
    send_byte(8'h02, '1, 8'h00, 1'b0);
    send_byte(8'h4C, '0, 8'h00, 1'b0);
    send_byte(8'h90, '1, 8'h00, 1'b0);
    send_byte(8'h08, '0, 8'h00, 1'b0);
  endtask

  task automatic test_stride_window();
    // stride_max below stride_min: stride is stride_min
    configure(31'd1, 31'd4, 31'd3, 31'd1, F_ADD, 9'h001, 5'd0, 16'h0000);
    send_byte(8'h11, '1, 8'h00, 1'b1);
    send_byte(8'h22, '1, 8'h00, 1'b0);
    send_byte(8'h33, '0, 8'h00, 1'b0);
    send_byte(8'h44, '1, 8'h00, 1'b0);
    send_byte(8'h55, '0, 8'h00, 1'b0);
    configure(TOP, TOP, TOP, TOP, 5'h1F, 9'h0FF, 5'h08, 16'hFFFF);
    send_byte(8'hFF, '1, 8'hFF, 1'b1);
    send_byte(8'h00, '0, 8'h00, 1'b0);
  endtask

  task automatic test_random_traffic();
    logic [30:0] start_off, end_off, smin, smax;
    logic [4:0]  mode, shift;
    logic [8:0]  add;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin gap_pct = 0; stall_pct = 0; end
        1: begin gap_pct = 66; stall_pct = 0; end
        2: begin gap_pct = 0; stall_pct = 66; end
        default: begin gap_pct = 13; stall_pct = 13; end
      endcase
      repeat (2) begin
        start_off = ($urandom_range(7) == 0) ? 31'($urandom_range(1 << 30))
                                             : 31'($urandom_range(24));
        case ($urandom_range(9))
          0: end_off = 31'd0;
          1: end_off = TOP;
          default: end_off = start_off + 31'($urandom_range(400));
        endcase
        smin = ($urandom_range(9) == 0) ? TOP : 31'($urandom_range(4));
        case ($urandom_range(9))
          0: smax = TOP;
          1: smax = 31'($urandom_range(3));
          default: smax = (smin == TOP) ? TOP : smin + 31'($urandom_range(6));
        endcase
        mode = 5'($urandom_range(31));
        if ($urandom_range(9) < 7) mode[MODE_RANDOM] = 1'b0;
        add = 9'($urandom_range(510) - 255);
        shift = ($urandom_range(4) == 0) ? 5'($urandom_range(31))
                                         : 5'($urandom_range(16) - 8);
        configure(start_off, end_off, smin, smax, mode, add, shift, 16'($urandom));
        random_bytes(80);
      end
    end
  endtask

  // hold the result side so the block backs up, then drain before resuming
  task automatic test_backpressure();
    gap_pct = 0;
    stall_pct = 0;
    configure(31'd0, TOP, 31'd1, 31'd1, F_ADD | F_PROTECT, 9'h003, 5'd0, 16'h0000);
    recv_hold = 200;
    random_bytes(12);
    wait_drained();
    random_bytes(6);
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    din_if.valid = 1'b0;
    din_if.data_byte = '0;
    din_if.rand_draw = '0;
    din_if.rand_byte = '0;
    din_if.first_of_stream = 1'b0;
    dout_if.ready = 1'b0;
    errs = 0;
    quiet = 0;
    gap_pct = 0;
    stall_pct = 0;
    recv_hold = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_corrupt_modes();
    test_opcode_guard();
    test_stride_window();
    test_random_traffic();
    test_backpressure();
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    if (errs == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

FILE: files.f
hdl/bsfi_pkg.sv
hdl/bsfi_if.sv
hdl/bsfi_mod_unit.sv
hdl/bsfi_corrupt.sv
hdl/byte_stream_fault_injector_unit.sv
hdl/bsfi_checker.sv
tb/byte_stream_fault_injector_unit_tb.sv
